// ----- rtl/color_bar_sweep_pattern_gen_defines.svh -----
// Assertion helpers shared by the color-bar generator modules.
`ifndef COLOR_BAR_SWEEP_PATTERN_GEN_DEFINES_SVH
`define COLOR_BAR_SWEEP_PATTERN_GEN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cbs_pkg.sv -----
package cbs_pkg;

    localparam int BAR_COUNT = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIPE_WIDTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_YUV_MODE     = 2'd3;

    localparam logic [12:0] RST_ACTIVE_WIDTH = 13'd1920;
    localparam logic [11:0] RST_BAND_ROWS    = 12'd96;
    localparam logic [10:0] RST_STRIPE_WIDTH = 11'd64;

    localparam logic [2:0] BAR_WHITE = 3'd0;
    localparam logic [2:0] BAR_BLACK = 3'd7;

    localparam logic [1:0] BYTES_YUV = 2'd2;
    localparam logic [1:0] BYTES_RGB = 2'd3;

    // Stripe phase advance per frame, in pixels.
    localparam logic [3:0] SWEEP_STEP = 4'd8;

    typedef enum logic [1:0] {
        ST_SETTLE,
        ST_LOAD,
        ST_REDUCE,
        ST_RUN
    } sweep_state_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } color_t;

    typedef struct packed {
        logic [1:0] byte_count;
        logic [7:0] byte_third;
        logic [7:0] byte_second;
        logic [7:0] byte_first;
    } pixel_t;

    function automatic color_t bar_color(input logic [2:0] idx);
        color_t c;
        unique case (idx)
            3'd0:    c = '{8'd255, 8'd255, 8'd255, 8'd235, 8'd128, 8'd128};
            3'd1:    c = '{8'd255, 8'd255, 8'd0,   8'd210, 8'd16,  8'd146};
            3'd2:    c = '{8'd0,   8'd255, 8'd255, 8'd170, 8'd166, 8'd16};
            3'd3:    c = '{8'd0,   8'd255, 8'd0,   8'd145, 8'd54,  8'd34};
            3'd4:    c = '{8'd255, 8'd0,   8'd255, 8'd106, 8'd202, 8'd222};
            3'd5:    c = '{8'd255, 8'd0,   8'd0,   8'd81,  8'd90,  8'd240};
            3'd6:    c = '{8'd0,   8'd0,   8'd255, 8'd41,  8'd240, 8'd110};
            default: c = '{8'd0,   8'd0,   8'd0,   8'd16,  8'd128, 8'd128};
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/cbs_cfg.sv -----
module cbs_cfg #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cbs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  cfg_write,
    output logic [11:0]                           band_rows,
    output logic [10:0]                           stripe_width,
    output logic                                  yuv_mode,
    output logic [$clog2(MAX_WIDTH+1)-1:0]        line_w,
    output logic [$clog2(MAX_WIDTH+1)-1:0]        fold_limit,
    output logic [$clog2(MAX_WIDTH+1):0]          period,
    output logic [3:0]                            step,
    output logic [cbs_pkg::BAR_COUNT-2:0][$clog2(MAX_WIDTH+1)-1:0] bar_edge
);
    import cbs_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [12:0] active_width_reg;
    logic [11:0] band_rows_reg;
    logic [10:0] stripe_width_reg;
    logic        yuv_mode_reg;

    logic [WW-1:0] line_w_reg, line_w_next;
    logic [WW-1:0] range_reg, range_next;
    logic [WW:0]   period_reg, period_next;
    logic [3:0]    step_reg, step_next;
    logic [BAR_COUNT-2:0][WW-1:0] edge_reg, edge_next;
    logic [WW-4:0] bar_w;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_width_reg <= RST_ACTIVE_WIDTH;
            band_rows_reg    <= RST_BAND_ROWS;
            stripe_width_reg <= RST_STRIPE_WIDTH;
            yuv_mode_reg     <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_ACTIVE_WIDTH: active_width_reg <= cfg_data;
                CFG_BAND_ROWS:    band_rows_reg    <= cfg_data[11:0];
                CFG_STRIPE_WIDTH: stripe_width_reg <= cfg_data[10:0];
                CFG_YUV_MODE:     yuv_mode_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Values derived from the configuration registers are themselves registered.
    always_comb begin
        line_w_next = (32'(active_width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH)
                                                          : WW'(active_width_reg);
        range_next  = (32'(stripe_width_reg) < 32'(line_w_next))
                    ? WW'(32'(line_w_next) - 32'(stripe_width_reg)) : '0;
        period_next = {range_next, 1'b0};
        // Line width over eight, rounded down to even.
        bar_w = {line_w_next[WW-1:4], 1'b0};
        for (int k = 0; k < BAR_COUNT - 1; k++) begin
            edge_next[k] = WW'((k + 1) * int'(bar_w));
        end
        // Advance of one frame, reduced by the period; the period is even.
        if (period_next > (WW+1)'(SWEEP_STEP)) begin
            step_next = SWEEP_STEP;
        end else if (period_next == (WW+1)'(6)) begin
            step_next = 4'd2;
        end else begin
            step_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        line_w_reg <= line_w_next;
        range_reg  <= range_next;
        period_reg <= period_next;
        step_reg   <= step_next;
        edge_reg   <= edge_next;
    end

    assign band_rows    = band_rows_reg;
    assign stripe_width = stripe_width_reg;
    assign yuv_mode     = yuv_mode_reg;
    assign line_w       = line_w_reg;
    assign fold_limit   = range_reg;
    assign period       = period_reg;
    assign step         = step_reg;
    assign bar_edge     = edge_reg;

endmodule

// ----- rtl/cbs_sweep.sv -----
`include "color_bar_sweep_pattern_gen_defines.svh"

module cbs_sweep #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write,
    input  logic [$clog2(MAX_WIDTH+1):0]        period,
    input  logic [3:0]                          step,
    input  logic                                take,
    input  logic                                advance,
    output logic                                busy,
    output logic [$clog2(2*MAX_WIDTH)-1:0]      item_phase
);
    import cbs_pkg::*;

    localparam int PW = $clog2(2 * MAX_WIDTH);
    localparam int DW = 2 * PW;
    localparam int CW = $clog2(PW + 1);

    sweep_state_t  state_reg, state_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW:0]   sum;
    logic [PW-1:0] adv_phase;

    // Per-frame step: the reduced phase is below the period and so is the
    // step, so one conditional subtract keeps the sum in range.
    always_comb begin
        sum = (PW+1)'(rem_reg) + (PW+1)'(step);
        if (period == '0) begin
            adv_phase = '0;
        end else if (advance) begin
            adv_phase = (sum >= (PW+1)'(period)) ? PW'(sum - (PW+1)'(period))
                                                 : PW'(sum);
        end else begin
            adv_phase = rem_reg;
        end
    end

    // The phase itself changes only when a pixel is taken; the reduced copy
    // is rebuilt from it after every write.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_SETTLE: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                rem_next   = phase_reg;
                dvs_next   = DW'(period) << (PW - 1);
                cnt_next   = CW'(PW);
                state_next = ST_REDUCE;
            end
            ST_REDUCE: begin
                // Restoring remainder of the phase by the new period.
                if (DW'(rem_reg) >= dvs_reg) begin
                    rem_next = rem_reg - PW'(dvs_reg);
                end
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (take) begin
                    phase_next = adv_phase;
                    rem_next   = adv_phase;
                end
            end
            default: state_next = ST_SETTLE;
        endcase
        if (cfg_write) begin
            state_next = ST_SETTLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SETTLE;
            phase_reg <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvs_reg <= dvs_next;
    end

    assign busy       = (state_reg != ST_RUN);
    assign item_phase = adv_phase;

    `CBS_ASSERT_SAME(a_phase_in_period, aclk, aresetn,
        state_reg == ST_RUN && period != '0, (PW+1)'(rem_reg) < (PW+1)'(period),
        "sweep phase outside its period")
    `CBS_ASSERT_NEXT(a_write_rereduces, aclk, aresetn, cfg_write, state_reg == ST_SETTLE,
        "register write did not restart phase reduction")

endmodule

// ----- rtl/cbs_render.sv -----
`include "color_bar_sweep_pattern_gen_defines.svh"

module cbs_render #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [11:0]                         column,
    input  logic [11:0]                         line,
    input  logic [$clog2(2*MAX_WIDTH)-1:0]      phase,
    input  logic [11:0]                         band_rows,
    input  logic [10:0]                         stripe_width,
    input  logic                                yuv_mode,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      line_w,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      fold_limit,
    input  logic [$clog2(MAX_WIDTH+1):0]        period,
    input  logic [cbs_pkg::BAR_COUNT-2:0][$clog2(MAX_WIDTH+1)-1:0] bar_edge,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cbs_pkg::pixel_t                     pixel
);
    import cbs_pkg::*;

    localparam int PW = $clog2(2 * MAX_WIDTH);

    logic          out_vld_reg;
    pixel_t        pix_reg, pix_next;
    logic          take;
    logic [PW-1:0] fold;
    logic [PW-1:0] stripe_x;
    logic          col_in_line;
    logic          in_stripe;
    logic [2:0]    bar_idx;
    logic [2:0]    idx;
    color_t        c;

    assign in_ready = !out_vld_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        // Stripe start bounces: the phase folds back past the sweep range.
        fold = (32'(phase) > 32'(fold_limit)) ? PW'(32'(period) - 32'(phase)) : phase;
        stripe_x = (period == '0) ? '0 : {fold[PW-1:1], 1'b0};
        in_stripe = (32'(column) >= 32'(stripe_x))
                 && (32'(column) < 32'(stripe_x) + 32'(stripe_width));
        col_in_line = 32'(column) < 32'(line_w);

        bar_idx = '0;
        for (int k = 0; k < BAR_COUNT - 1; k++) begin
            if (32'(column) >= 32'(bar_edge[k])) begin
                bar_idx = bar_idx + 3'd1;
            end
        end

        // A zero bar width blacks out the bars; band borders and stripe still apply.
        if (!col_in_line || bar_edge[0] == '0) begin
            idx = BAR_BLACK;
        end else begin
            idx = bar_idx;
        end
        if (col_in_line && line < band_rows) begin
            if (line == 12'd0 || line == band_rows - 12'd1) begin
                idx = BAR_BLACK;
            end else if (in_stripe) begin
                idx = BAR_WHITE;
            end
        end

        c = bar_color(idx);
        if (yuv_mode) begin
            pix_next.byte_first  = column[0] ? c.v : c.u;
            pix_next.byte_second = c.y;
            pix_next.byte_third  = 8'd0;
            pix_next.byte_count  = BYTES_YUV;
        end else begin
            pix_next.byte_first  = c.b;
            pix_next.byte_second = c.g;
            pix_next.byte_third  = c.r;
            pix_next.byte_count  = BYTES_RGB;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (take) begin
            out_vld_reg <= 1'b1;
        end else if (out_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign pixel     = pix_reg;

    `CBS_ASSERT_NEXT(a_take_shows, aclk, aresetn, take, out_vld_reg,
        "rendered pixel not presented")
    `CBS_ASSERT_SAME(a_yuv_third_zero, aclk, aresetn,
        out_vld_reg && pix_reg.byte_count == BYTES_YUV, pix_reg.byte_third == 8'd0,
        "third byte set in UYVY output")

endmodule

// ----- rtl/color_bar_sweep_pattern_gen.sv -----
// Color-bar test pattern generator with a sweeping white stripe. Each input
// transfer names a pixel (column, line, and a flag that steps the stripe by
// one frame first) and yields one output transfer with that pixel's bytes:
// B,G,R with a count of 3, or UYVY bytes (U or V by column parity, then Y)
// with a count of 2. The block takes one pixel per clock unless the reduction
// or a stalled output holds s_tready low, and passes it through the input
// register, where the stripe phase is stepped, and the render logic into the
// result register. After reset and after every register write, the stripe
// phase is reduced modulo the new sweep period by a restoring remainder unit,
// one bit per cycle; s_tready stays low meanwhile, while register writes are
// always taken. The user must write registers only while no pixel is in
// flight; the block itself does not enforce it.
`include "color_bar_sweep_pattern_gen_defines.svh"

module color_bar_sweep_pattern_gen #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // column[11:0], line[23:12]
    input  logic [0:0]                        s_tuser,   // advance_frame[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // byte_first, byte_second, byte_third
    output logic [1:0]                        m_tuser,   // byte_count[1:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cbs_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(2 * MAX_WIDTH);

    logic          cfg_write;
    logic [11:0]   band_rows;
    logic [10:0]   stripe_width;
    logic          yuv_mode;
    logic [WW-1:0] line_w;
    logic [WW-1:0] fold_limit;
    logic [WW:0]   period;
    logic [3:0]    step;
    logic [BAR_COUNT-2:0][WW-1:0] bar_edge;

    logic          busy;
    logic [PW-1:0] item_phase;
    logic          accept;
    logic          r_ready;
    pixel_t        pixel;

    logic          in_vld_reg, in_vld_next;
    logic [11:0]   col_reg;
    logic [11:0]   line_reg;
    logic [PW-1:0] phase_reg;

    cbs_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_write    (cfg_write),
        .band_rows    (band_rows),
        .stripe_width (stripe_width),
        .yuv_mode     (yuv_mode),
        .line_w       (line_w),
        .fold_limit   (fold_limit),
        .period       (period),
        .step         (step),
        .bar_edge     (bar_edge)
    );

    cbs_sweep #(.MAX_WIDTH(MAX_WIDTH)) u_sweep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_write),
        .period     (period),
        .step       (step),
        .take       (accept),
        .advance    (s_tuser[0]),
        .busy       (busy),
        .item_phase (item_phase)
    );

    // The input register moves on whenever the render stage takes its item.
    assign s_tready = !busy && (!in_vld_reg || r_ready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (accept) begin
            in_vld_next = 1'b1;
        end else if (r_ready) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg   <= s_tdata[11:0];
            line_reg  <= s_tdata[23:12];
            phase_reg <= item_phase;
        end
    end

    cbs_render #(.MAX_WIDTH(MAX_WIDTH)) u_render (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (in_vld_reg),
        .in_ready     (r_ready),
        .column       (col_reg),
        .line         (line_reg),
        .phase        (phase_reg),
        .band_rows    (band_rows),
        .stripe_width (stripe_width),
        .yuv_mode     (yuv_mode),
        .line_w       (line_w),
        .fold_limit   (fold_limit),
        .period       (period),
        .bar_edge     (bar_edge),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel        (pixel)
    );

    assign m_tdata = {pixel.byte_third, pixel.byte_second, pixel.byte_first};
    assign m_tuser = pixel.byte_count;

    `CBS_ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_tvalid && s_tready, in_vld_reg,
        "accepted pixel missing from input register")

endmodule

// ----- tb/color_bar_sweep_pattern_gen_test.sv -----
`timescale 1ns / 100ps

module color_bar_sweep_pattern_gen_test;
    import cbs_pkg::*;

    localparam int MAX_WIDTH   = 4096;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic        adv;
    } pixel_req_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register copies and stripe phase as the generator should hold them.
    logic [12:0] cfg_width  = RST_ACTIVE_WIDTH;
    logic [11:0] cfg_band   = RST_BAND_ROWS;
    logic [10:0] cfg_stripe = RST_STRIPE_WIDTH;
    logic        cfg_yuv    = 1'b0;
    int unsigned stripe_phase = 0;

    pixel_req_t pending_pixels[$];
    pixel_t     expected_pixels[$];

    int failures      = 0;
    int pixels_seen   = 0;
    int reg_writes    = 0;
    int settings_used = 1;
    int cycle_count   = 0;
    int gap_mode      = 0;
    int rdy_mode      = 0;
    int gap_left      = 0;
    int burst_left    = 1;
    int stall_tick    = 0;

    color_bar_sweep_pattern_gen #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Steps the stripe phase and renders the bytes of one pixel.
    function automatic pixel_t render_pixel(input logic [11:0] col, input logic [11:0] row,
                                            input logic adv);
        int unsigned w, span, period, x, bar_w;
        logic [2:0]  idx;
        logic [7:0]  r, g, b, y, u, v;
        pixel_t      px;
        w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        span = (cfg_stripe < w) ? w - cfg_stripe : 0;
        period = 2 * span;
        x = 0;
        if (period == 0) begin
            stripe_phase = 0;
        end else begin
            // A register change can leave the phase outside the new period.
            stripe_phase = stripe_phase % period;
            if (adv) begin
                stripe_phase = (stripe_phase + SWEEP_STEP) % period;
            end
            x = stripe_phase;
            if (x > span) begin
                x = period - x;
            end
            x = x & ~32'd1;
        end
        if (col >= w) begin
            idx = BAR_BLACK;
        end else begin
            bar_w = (w / BAR_COUNT) & ~32'd1;
            if (bar_w == 0) begin
                idx = BAR_BLACK;
            end else if (col / bar_w > BAR_COUNT - 1) begin
                idx = 3'(BAR_COUNT - 1);
            end else begin
                idx = 3'(col / bar_w);
            end
            if (row < cfg_band) begin
                if (row == 0 || row == cfg_band - 12'd1) begin
                    idx = BAR_BLACK;
                end else if (col >= x && col < x + cfg_stripe) begin
                    idx = BAR_WHITE;
                end
            end
        end
        case (idx)
            BAR_WHITE: {r, g, b, y, u, v} = {8'd255, 8'd255, 8'd255, 8'd235, 8'd128, 8'd128};
            3'd1:      {r, g, b, y, u, v} = {8'd255, 8'd255, 8'd0,   8'd210, 8'd16,  8'd146};
            3'd2:      {r, g, b, y, u, v} = {8'd0,   8'd255, 8'd255, 8'd170, 8'd166, 8'd16};
            3'd3:      {r, g, b, y, u, v} = {8'd0,   8'd255, 8'd0,   8'd145, 8'd54,  8'd34};
            3'd4:      {r, g, b, y, u, v} = {8'd255, 8'd0,   8'd255, 8'd106, 8'd202, 8'd222};
            3'd5:      {r, g, b, y, u, v} = {8'd255, 8'd0,   8'd0,   8'd81,  8'd90,  8'd240};
            3'd6:      {r, g, b, y, u, v} = {8'd0,   8'd0,   8'd255, 8'd41,  8'd240, 8'd110};
            default:   {r, g, b, y, u, v} = {8'd0,   8'd0,   8'd0,   8'd16,  8'd128, 8'd128};
        endcase
        if (cfg_yuv) begin
            px.byte_first  = col[0] ? v : u;
            px.byte_second = y;
            px.byte_third  = 8'd0;
            px.byte_count  = BYTES_YUV;
        end else begin
            px.byte_first  = b;
            px.byte_second = g;
            px.byte_third  = r;
            px.byte_count  = BYTES_RGB;
        end
        return px;
    endfunction

    // Driver: random-length bursts with random gaps in gap mode; tvalid holds until accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(render_pixel(s_tdata[11:0], s_tdata[23:12],
                                                       s_tuser[0]));
                void'(pending_pixels.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_pixels[0].row, pending_pixels[0].col};
                    s_tuser  <= pending_pixels[0].adv;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = gap_mode ? $urandom_range(0, 6) : 0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        failures++;
    endtask

    // Monitor: checks each output transfer and stalls the result side.
    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (expected_pixels.size() == 0) begin
                $display("%0t ns: output transfer with nothing expected, expected none, got %h",
                         $time, got);
                failures++;
            end else begin
                want = expected_pixels.pop_front();
                pixels_seen++;
                if (got.byte_first !== want.byte_first) begin
                    report("byte_first", want.byte_first, got.byte_first);
                end
                if (got.byte_second !== want.byte_second) begin
                    report("byte_second", want.byte_second, got.byte_second);
                end
                if (got.byte_third !== want.byte_third) begin
                    report("byte_third", want.byte_third, got.byte_third);
                end
                if (got.byte_count !== want.byte_count) begin
                    report("byte_count", 8'(want.byte_count), 8'(got.byte_count));
                end
            end
        end
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 2) != 0);
            default: m_tready <= ((stall_tick % 7) >= 3);
        endcase
        stall_tick++;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d outputs still due", cycle_count,
                     expected_pixels.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ACTIVE_WIDTH: cfg_width  = 13'(val);
            CFG_BAND_ROWS:    cfg_band   = 12'(val);
            CFG_STRIPE_WIDTH: cfg_stripe = 11'(val);
            default:          cfg_yuv    = val[0];
        endcase
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic configure(input int unsigned width, input int unsigned band,
                             input int unsigned stripe, input int unsigned yuv);
        write_reg(CFG_ACTIVE_WIDTH, width);
        write_reg(CFG_BAND_ROWS, band);
        write_reg(CFG_STRIPE_WIDTH, stripe);
        write_reg(CFG_YUV_MODE, yuv);
        settings_used++;
    endtask

    task automatic push_pixel(input int unsigned col, input int unsigned row, input bit adv);
        pixel_req_t p;
        p.col = 12'(col);
        p.row = 12'(row);
        p.adv = adv;
        pending_pixels.push_back(p);
    endtask

    // Mostly short runs along a line, starting a new frame now and then; the rest is noise.
    task automatic queue_pixels(input int n);
        int unsigned w, maxc, start, row, run;
        bit          adv;
        w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        maxc = (w + 3 > 4095) ? 4095 : w + 3;
        while (n > 0) begin
            if ($urandom_range(0, 9) < 2) begin
                push_pixel($urandom, $urandom, 1'($urandom_range(0, 1)));
                n--;
            end else begin
                case ($urandom_range(0, 3))
                    0:       row = 0;
                    1:       row = (cfg_band == 0) ? $urandom_range(0, 4095) : cfg_band - 1;
                    2:       row = (cfg_band > 2) ? $urandom_range(1, cfg_band - 2)
                                                  : $urandom_range(0, 4095);
                    default: row = $urandom_range(0, 4095);
                endcase
                start = $urandom_range(0, maxc);
                run   = $urandom_range(1, 16);
                adv   = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < run; k++) begin
                    push_pixel(start + k, row, adv && k == 0);
                end
                n -= run;
            end
        end
    endtask

    task automatic wait_drained;
        while (pending_pixels.size() > 0 || expected_pixels.size() > 0 || s_tvalid) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_setting(input int unsigned width, input int unsigned band,
                               input int unsigned stripe, input int unsigned yuv,
                               input int n, input int gaps, input int stalls);
        configure(width, band, stripe, yuv);
        gap_mode = gaps;
        rdy_mode = stalls;
        queue_pixels(n);
        wait_drained();
    endtask

    initial begin
        int unsigned width, stripe_max;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: 1920 pixels, bars of 240, band of 96 rows, stripe of 64.
        push_pixel(0, 0, 0);
        push_pixel(1919, 95, 0);
        push_pixel(0, 96, 0);
        push_pixel(239, 96, 0);
        push_pixel(240, 96, 0);
        push_pixel(480, 300, 0);
        push_pixel(720, 300, 0);
        push_pixel(960, 300, 0);
        push_pixel(1200, 300, 0);
        push_pixel(1440, 300, 0);
        push_pixel(1680, 300, 0);
        push_pixel(1919, 4095, 0);
        push_pixel(1920, 10, 0);
        push_pixel(4095, 4095, 1);
        // The stripe now starts at column 8.
        push_pixel(7, 1, 0);
        push_pixel(9, 1, 0);
        push_pixel(71, 1, 0);
        push_pixel(72, 1, 0);
        push_pixel(300, 50, 1);
        wait_drained();

        configure(4096, 4095, 1024, 1);
        gap_mode = 1;
        rdy_mode = 1;
        push_pixel(0, 200, 0);
        push_pixel(1, 200, 0);
        push_pixel(4095, 0, 1);
        push_pixel(2, 1, 1);
        queue_pixels(80);
        wait_drained();

        run_setting(128, 2, 2, 0, 80, 0, 0);
        // Width beyond the maximum with no band at all.
        run_setting(8191, 0, 2047, 1, 80, 1, 2);
        // Odd width, stripe wider than the line, band of a single row.
        run_setting(131, 1, 200, 0, 80, 1, 1);
        // Too narrow for any bar.
        run_setting(10, 5, 4, 1, 80, 0, 1);
        run_setting(0, 3, 2, 0, 30, 1, 0);
        run_setting(1920, 96, 64, 1, 80, 1, 2);

        for (int s = 0; s < 6; s++) begin
            width = 2 * $urandom_range(64, 2048);
            stripe_max = (width - 8 > 1024) ? 1024 : width - 8;
            run_setting(width, $urandom_range(2, 400), 2 * $urandom_range(1, stripe_max / 2),
                        $urandom_range(0, 1), 90, $urandom_range(0, 1), $urandom_range(0, 2));
        end

        if (expected_pixels.size() != 0) begin
            $display("%0t ns: %0d outputs never arrived", $time, expected_pixels.size());
            failures++;
        end
        $display("Checked %0d pixels under %0d register settings (%0d register writes),",
                 pixels_seen, settings_used, reg_writes);
        $display("in BGR and UYVY, covering bars, band borders, stripe sweep and blanking.");
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
